/* rtl/core/assert_macros.svh */
// Assertion macros shared by the sliding window maximum RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/swm_pkg.sv */
// Shared types and constants of the sliding window maximum
package swm_pkg;

   localparam int WINDOW_MAX_DEFAULT   = 64;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int CFG_WIDTH            = 7;
   localparam logic [CFG_WIDTH-1:0] CFG_RESET = 7'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_EMIT
   } swm_state_type;

   typedef struct packed {
      logic shift;
      logic restart;
   } swm_ctl_type;

endpackage

/* rtl/core/swm_channels.sv */
// Handshake channel interfaces of the sliding window maximum
interface swm_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           start_req;

   modport source (output valid, output sample, output start_req, input ready);
   modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] window_max;

   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_csr_if import swm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CFG_WIDTH-1:0] window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

/* rtl/core/swm_cell.sv */
// One cell of the deque chain: holds a live flag and a sample of known age
module swm_cell
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int K_WIDTH      = 7,
   parameter int INDEX        = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swm_ctl_type                    ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic        [K_WIDTH-1:0]      k,
   input  logic                           prev_alive,
   input  logic signed [SAMPLE_WIDTH-1:0] prev_value,
   output logic                           alive,
   output logic signed [SAMPLE_WIDTH-1:0] value,
   output logic                           next_alive,
   output logic signed [SAMPLE_WIDTH-1:0] next_value
);

   localparam bit HEAD = (INDEX == 0);

   logic                           alive_ff;
   logic                           alive_in;
   logic signed [SAMPLE_WIDTH-1:0] value_ff;
   logic signed [SAMPLE_WIDTH-1:0] value_in;
   logic                           keep;

   // head always keeps the sample; others drop on restart, on a newer sample not smaller, or once too old
   assign keep = prev_alive && (HEAD || (!ctl.restart && (prev_value > sample) &&
                                         (k > K_WIDTH'(INDEX))));

   always_comb begin
      alive_in = alive_ff;
      value_in = value_ff;
      if (ctl.shift) begin
         alive_in = keep;
         value_in = prev_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b0;
      end else begin
         alive_ff <= alive_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign alive      = alive_ff;
   assign value      = value_ff;
   assign next_alive = alive_in;
   assign next_value = value_in;

endmodule

/* rtl/core/swm_reduce.sv */
// Iterative pairwise search for the oldest live cell of the chain
module swm_reduce
   import swm_pkg::*;
#(
   parameter int DEPTH        = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic                           step,
   input  logic                           load_alive [DEPTH],
   input  logic signed [SAMPLE_WIDTH-1:0] load_value [DEPTH],
   output logic                           front_alive,
   output logic signed [SAMPLE_WIDTH-1:0] front_value
);

   localparam int LEVELS = $clog2(DEPTH);
   localparam int SLOTS  = 1 << LEVELS;

   logic                           slot_alive_ff [SLOTS];
   logic signed [SAMPLE_WIDTH-1:0] slot_value_ff [SLOTS];

   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      logic                           ld_alive;
      logic signed [SAMPLE_WIDTH-1:0] ld_value;
      logic                           st_alive;
      logic signed [SAMPLE_WIDTH-1:0] st_value;

      if (i < DEPTH) begin : g_load
         assign ld_alive = load_alive[i];
         assign ld_value = load_value[i];
      end else begin : g_pad
         assign ld_alive = 1'b0;
         assign ld_value = '0;
      end

      // the higher slot of a pair holds the older cells
      if (i < SLOTS / 2) begin : g_pair
         assign st_alive = slot_alive_ff[2*i+1] || slot_alive_ff[2*i];
         assign st_value = slot_alive_ff[2*i+1] ? slot_value_ff[2*i+1]
                                                : slot_value_ff[2*i];
      end else begin : g_hold
         assign st_alive = slot_alive_ff[i];
         assign st_value = slot_value_ff[i];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            slot_alive_ff[i] <= 1'b0;
         end else if (load) begin
            slot_alive_ff[i] <= ld_alive;
         end else if (step) begin
            slot_alive_ff[i] <= st_alive;
         end
      end

      always_ff @(posedge clock) begin
         if (load) begin
            slot_value_ff[i] <= ld_value;
         end else if (step) begin
            slot_value_ff[i] <= st_value;
         end
      end
   end

   assign front_alive = slot_alive_ff[0];
   assign front_value = slot_value_ff[0];

endmodule

/* rtl/core/sliding_window_maximum.sv */
// Sliding window maximum: top level with cell chain, search unit and handshakes
// Gives, for each accepted sample, the largest of the last window_size samples of the
// current sequence (start_req opens a new one), once that many samples have arrived;
// earlier samples give no word. A chain of WINDOW_MAX cells keeps the monotonic deque
// and updates every cell in the cycle a sample is taken; the front is then found by a
// pairwise search of $clog2(WINDOW_MAX) levels, one level a cycle. The next sample is
// taken only after the search and the emit state, which waits while an earlier result
// word is still unread; the emit state loads the result word into the output register.
// A result word waits in the output register while the next sample is processed.
`include "assert_macros.svh"

module sliding_window_maximum
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   swm_req_if.sink     req_if,
   swm_rsp_if.source   rsp_if,
   swm_csr_if.sink     csr_if
);

   localparam int K_WIDTH    = $clog2(WINDOW_MAX + 1);
   localparam int CMP_WIDTH  = (K_WIDTH > CFG_WIDTH) ? K_WIDTH : CFG_WIDTH;
   localparam int LEVELS     = $clog2(WINDOW_MAX);
   localparam int LV_WIDTH   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int LAST_LEVEL = (LEVELS > 0) ? LEVELS - 1 : 0;

   swm_state_type                  state_ff;
   swm_state_type                  state_in;
   logic [LV_WIDTH-1:0]            level_ff;
   logic [LV_WIDTH-1:0]            level_in;
   logic [CFG_WIDTH-1:0]           window_size_ff;
   logic [K_WIDTH-1:0]             filled_ff;
   logic [K_WIDTH-1:0]             filled_in;
   logic [K_WIDTH-1:0]             filled_base;
   logic                           emit_ff;
   logic                           emit_in;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] window_max_ff;
   logic [CMP_WIDTH-1:0]           size_wide;
   logic [K_WIDTH-1:0]             k;
   logic                           req_accept;
   logic                           red_step;
   logic                           out_load;
   swm_ctl_type                    ctl;
   logic                           front_alive;
   logic signed [SAMPLE_WIDTH-1:0] front_value;

   logic                           cell_alive [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
   logic                           cell_next_alive [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] cell_next_value [WINDOW_MAX];

   assign req_accept = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= CFG_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         window_size_ff <= csr_if.window_size;
      end
   end

   // clamp the window to 1..WINDOW_MAX
   assign size_wide = CMP_WIDTH'(window_size_ff);
   always_comb begin
      if (window_size_ff == '0) begin
         k = K_WIDTH'(1);
      end else if (size_wide > CMP_WIDTH'(WINDOW_MAX)) begin
         k = K_WIDTH'(WINDOW_MAX);
      end else begin
         k = K_WIDTH'(size_wide);
      end
   end

   assign ctl.shift   = req_accept;
   assign ctl.restart = req_if.start_req;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic                           prev_alive;
      logic signed [SAMPLE_WIDTH-1:0] prev_value;

      if (i == 0) begin : g_head
         assign prev_alive = 1'b1;
         assign prev_value = req_if.sample;
      end else begin : g_link
         assign prev_alive = cell_alive[i-1];
         assign prev_value = cell_value[i-1];
      end

      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .K_WIDTH      (K_WIDTH),
         .INDEX        (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .sample     (req_if.sample),
         .k          (k),
         .prev_alive (prev_alive),
         .prev_value (prev_value),
         .alive      (cell_alive[i]),
         .value      (cell_value[i]),
         .next_alive (cell_next_alive[i]),
         .next_value (cell_next_value[i])
      );
   end

   swm_reduce #(
      .DEPTH        (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_reduce (
      .clock       (clock),
      .reset       (reset),
      .load        (req_accept),
      .step        (red_step),
      .load_alive  (cell_next_alive),
      .load_value  (cell_next_value),
      .front_alive (front_alive),
      .front_value (front_value)
   );

   // sample count of the current sequence, saturating
   assign filled_base = req_if.start_req ? '0 : filled_ff;
   assign filled_in   = (filled_base < K_WIDTH'(WINDOW_MAX)) ? filled_base + K_WIDTH'(1)
                                                             : filled_base;
   assign emit_in     = (filled_in >= k);

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         emit_ff   <= 1'b0;
      end else if (req_accept) begin
         filled_ff <= filled_in;
         emit_ff   <= emit_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      red_step      = 1'b0;
      out_load      = 1'b0;
      req_if.ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               level_in = '0;
               state_in = (LEVELS == 0) ? ST_EMIT : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            red_step = 1'b1;
            level_in = level_ff + LV_WIDTH'(1);
            if (level_ff == LV_WIDTH'(LAST_LEVEL)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_if.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         window_max_ff <= front_value;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.window_max = window_max_ff;

   `SWM_ASSERT_NEXT(a_head_live, clock, reset, req_accept, cell_alive[0], "newest cell dead")
   `SWM_ASSERT_SAME(a_front_live, clock, reset, state_ff == ST_EMIT && emit_ff, front_alive, "empty")
   `SWM_ASSERT_SAME(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_EMIT, "rise")
   `SWM_ASSERT_SAME(a_level_range, clock, reset, state_ff == ST_REDUCE, level_ff <= LV_WIDTH'(LAST_LEVEL), "lv")

endmodule
